// ----- rtl/core/mca_pkg.sv -----
// Package for the memory credit admission block: payload structs, function codes,
// register indexes, refill constants and the saturating refill helper.
// No dependencies.
`timescale 1ns / 1ps

package mca_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 16;
    localparam int CHAN_W   = 4;
    localparam int CREDIT_W = 20;
    localparam int COUNT_W  = 11;
    localparam int RSPN_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Queue depths
    localparam int CLS_DEPTH_DEF = 4;
    localparam int RSP_DEPTH_DEF = 2;

    // Credit refill per tick for the L2 credits
    localparam logic [CREDIT_W-1:0] L2_ACCESS_REFILL = CREDIT_W'(64);
    localparam logic [CREDIT_W-1:0] L2_READ_REFILL   = CREDIT_W'(64);
    localparam logic [CREDIT_W-1:0] L2_WRITE_REFILL  = CREDIT_W'(64);

    // Reads on this channel split into responses of 128 bytes each
    localparam logic [CHAN_W-1:0] SPLIT_CHANNEL = CHAN_W'(10);
    localparam int SPLIT_SHIFT = 7;  // log2 of 128 bytes

    localparam logic [COUNT_W-1:0] QUEUE_LIMIT_RST = COUNT_W'(16);

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_CMPL  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_L2_BASE     = 3'd0,
        CFG_L2_WIN_SIZE = 3'd1,
        CFG_DDR_MAX     = 3'd2,
        CFG_DDR_REFILL  = 3'd3,
        CFG_L2_ACC_MAX  = 3'd4,
        CFG_L2_RD_MAX   = 3'd5,
        CFG_L2_WR_MAX   = 3'd6,
        CFG_QUEUE_LIMIT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_func             func;
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] byte_count;
        logic [CHAN_W-1:0] channel;
    } t_req;

    typedef struct packed {
        logic                accepted;
        logic                in_l2;
        logic [RSPN_W-1:0]   response_count;
        logic [COUNT_W-1:0]  outstanding;
        logic [CREDIT_W-1:0] ddr_credit_now;
    } t_rsp;

    // Classified request handed from front to back
    typedef struct packed {
        t_func             func;
        logic              in_l2;
        logic [SIZE_W-1:0] byte_count;
        logic [RSPN_W-1:0] resp_total;
    } t_cls;

    // Credit settings seen by the back end
    typedef struct packed {
        logic [CREDIT_W-1:0] ddr_max;
        logic [CREDIT_W-1:0] ddr_refill;
        logic [CREDIT_W-1:0] l2_acc_max;
        logic [CREDIT_W-1:0] l2_rd_max;
        logic [CREDIT_W-1:0] l2_wr_max;
        logic [COUNT_W-1:0]  queue_limit;
    } t_cfg;

    // Add a refill to a credit and clamp at its ceiling
    function automatic logic [CREDIT_W-1:0] f_refill(
        input logic [CREDIT_W-1:0] credit,
        input logic [CREDIT_W-1:0] add,
        input logic [CREDIT_W-1:0] max
    );
        logic [CREDIT_W:0] s;
        s = {1'b0, credit} + {1'b0, add};
        return (s > {1'b0, max}) ? max : s[CREDIT_W-1:0];
    endfunction

endpackage

// ----- rtl/core/mca_fifo.sv -----
// Small first-word-fall-through queue built from flops.
// Generic width and depth; no package dependency.
`timescale 1ns / 1ps

module mca_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr, rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (rd && !wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- rtl/core/mca_front.sv -----
// Front end: classifies each request by address window and response count.
// Depends on mca_pkg.
`timescale 1ns / 1ps

module mca_front (
    input  mca_pkg::t_req                      i_req,
    input  logic [mca_pkg::ADDR_W-1:0]         i_l2_base,
    input  logic [mca_pkg::ADDR_W-1:0]         i_l2_win_size,
    output mca_pkg::t_cls                      o_cls
);
    import mca_pkg::*;

    logic [ADDR_W:0]   win_end;
    logic              in_l2;
    logic [SIZE_W:0]   round_up;
    logic              split;

    // Window end carries one extra bit so it never wraps
    assign win_end = {1'b0, i_l2_base} + {1'b0, i_l2_win_size};
    assign in_l2   = (i_req.address >= i_l2_base) && ({1'b0, i_req.address} < win_end);

    // Split reads produce one response per 128 bytes, rounded up
    assign round_up = {1'b0, i_req.byte_count} + (SIZE_W + 1)'((1 << SPLIT_SHIFT) - 1);
    assign split    = (i_req.func == FUNC_READ) && (i_req.channel == SPLIT_CHANNEL);

    always_comb begin
        o_cls.func       = i_req.func;
        o_cls.in_l2      = in_l2;
        o_cls.byte_count = i_req.byte_count;
        o_cls.resp_total = split ? round_up[SIZE_W:SPLIT_SHIFT] : RSPN_W'(1);
    end

endmodule

// ----- rtl/core/mca_back.sv -----
// Back end: checks credits and queue limit, charges and refills credits,
// tracks outstanding accesses and builds the result beat. Depends on mca_pkg.
`timescale 1ns / 1ps

module mca_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mca_pkg::t_cfg i_cfg,
    input  mca_pkg::t_cls i_cls,
    input  logic          i_cls_valid,
    output logic          o_cls_pop,
    output mca_pkg::t_rsp o_rsp,
    input  logic          i_rsp_ready,
    output logic          o_rsp_push
);
    import mca_pkg::*;

    logic [CREDIT_W-1:0] r_ddr, n_ddr;
    logic [CREDIT_W-1:0] r_l2_acc, n_l2_acc;
    logic [CREDIT_W-1:0] r_l2_rd, n_l2_rd;
    logic [CREDIT_W-1:0] r_l2_wr, n_l2_wr;
    logic [COUNT_W-1:0]  r_count, n_count;

    logic                fire;
    logic                is_req, is_write;
    logic [CREDIT_W-1:0] size_ext;
    logic [CREDIT_W-1:0] acc_credit, rw_credit;
    logic                admit;
    logic [RSPN_W-1:0]   rsp_n;
    logic [COUNT_W:0]    count_sum;
    logic [CREDIT_W-1:0] ddr_once;

    assign fire       = i_cls_valid && i_rsp_ready;
    assign o_cls_pop  = fire;
    assign o_rsp_push = fire;

    // Select region credits and decide admission
    always_comb begin
        is_req     = (i_cls.func == FUNC_READ) || (i_cls.func == FUNC_WRITE);
        is_write   = (i_cls.func == FUNC_WRITE);
        size_ext   = CREDIT_W'(i_cls.byte_count);
        acc_credit = i_cls.in_l2 ? r_l2_acc : r_ddr;
        rw_credit  = i_cls.in_l2 ? (is_write ? r_l2_wr : r_l2_rd) : r_ddr;
        admit      = is_req && (r_count < i_cfg.queue_limit)
                     && (size_ext < acc_credit) && (size_ext < rw_credit);
        rsp_n      = admit ? i_cls.resp_total : '0;
        count_sum  = {1'b0, r_count} + (COUNT_W + 1)'(rsp_n);
        ddr_once   = r_ddr - size_ext;
    end

    // Next credit and count values
    always_comb begin
        n_ddr    = r_ddr;
        n_l2_acc = r_l2_acc;
        n_l2_rd  = r_l2_rd;
        n_l2_wr  = r_l2_wr;
        n_count  = r_count;
        case (i_cls.func)
            FUNC_TICK: begin
                n_ddr    = f_refill(r_ddr, i_cfg.ddr_refill, i_cfg.ddr_max);
                n_l2_acc = f_refill(r_l2_acc, L2_ACCESS_REFILL, i_cfg.l2_acc_max);
                n_l2_rd  = f_refill(r_l2_rd, L2_READ_REFILL, i_cfg.l2_rd_max);
                n_l2_wr  = f_refill(r_l2_wr, L2_WRITE_REFILL, i_cfg.l2_wr_max);
            end
            FUNC_CMPL: begin
                if (r_count != '0) begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                if (admit) begin
                    n_count = count_sum[COUNT_W] ? '1 : count_sum[COUNT_W-1:0];
                    if (i_cls.in_l2) begin
                        n_l2_acc = r_l2_acc - size_ext;
                        if (is_write) begin
                            n_l2_wr = r_l2_wr - size_ext;
                        end else begin
                            n_l2_rd = r_l2_rd - size_ext;
                        end
                    end else begin
                        // DDR is charged twice, the second charge floors at zero
                        n_ddr = (ddr_once > size_ext) ? ddr_once - size_ext : '0;
                    end
                end
            end
        endcase
    end

    // Build the result beat from the updated state
    always_comb begin
        o_rsp.accepted       = admit;
        o_rsp.in_l2          = i_cls.in_l2;
        o_rsp.response_count = rsp_n;
        o_rsp.outstanding    = n_count;
        o_rsp.ddr_credit_now = n_ddr;
    end

    // Credits reset to zero, as do their ceilings in the config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ddr    <= '0;
            r_l2_acc <= '0;
            r_l2_rd  <= '0;
            r_l2_wr  <= '0;
            r_count  <= '0;
        end else if (fire) begin
            r_ddr    <= n_ddr;
            r_l2_acc <= n_l2_acc;
            r_l2_rd  <= n_l2_rd;
            r_l2_wr  <= n_l2_wr;
            r_count  <= n_count;
        end
    end

    // Only admitted requests report responses
    a_rsp_needs_admit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (rsp_n != '0) |-> admit)
        else $error("response count without admission");

    // Admission is for reads and writes only
    a_admit_is_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && admit |-> (i_cls.func == FUNC_READ) || (i_cls.func == FUNC_WRITE))
        else $error("admitted a tick or completion");

    // DDR credit never grows outside a tick
    a_ddr_no_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_cls.func != FUNC_TICK) |=> r_ddr <= $past(r_ddr))
        else $error("DDR credit grew without a tick");

    // State holds while no beat moves
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_count) && $stable(r_ddr))
        else $error("state changed without a beat");

endmodule

// ----- rtl/core/memory_credit_admission.sv -----
// Top level of the memory credit admission block: configuration registers,
// front classifier, request queue, credit back end and result queue.
// Accepted requests pass the request queue, the back end and then the result queue.
// Throughput: one item per cycle while the result queue is not full.
// Reset: queues empty, credits and outstanding count zero, registers at reset values.
`timescale 1ns / 1ps

module memory_credit_admission #(
    parameter int CLS_DEPTH = mca_pkg::CLS_DEPTH_DEF,
    parameter int RSP_DEPTH = mca_pkg::RSP_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    input  mca_pkg::t_req                      i_req,
    output logic                               full,
    input  logic                               pop,
    output mca_pkg::t_rsp                      o_rsp,
    output logic                               empty,
    input  logic                               i_cfg_we,
    input  logic [mca_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mca_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import mca_pkg::*;

    logic [ADDR_W-1:0] r_l2_base;
    logic [ADDR_W-1:0] r_l2_win_size;
    t_cfg              r_cfg;

    t_cls cls_in, cls_out;
    logic cls_empty, cls_pop;
    t_rsp rsp_in;
    logic rsp_full, rsp_push;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2_base         <= '0;
            r_l2_win_size     <= '0;
            r_cfg.ddr_max     <= '0;
            r_cfg.ddr_refill  <= '0;
            r_cfg.l2_acc_max  <= '0;
            r_cfg.l2_rd_max   <= '0;
            r_cfg.l2_wr_max   <= '0;
            r_cfg.queue_limit <= QUEUE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_L2_BASE:     r_l2_base         <= i_cfg_data[ADDR_W-1:0];
                CFG_L2_WIN_SIZE: r_l2_win_size     <= i_cfg_data[ADDR_W-1:0];
                CFG_DDR_MAX:     r_cfg.ddr_max     <= i_cfg_data[CREDIT_W-1:0];
                CFG_DDR_REFILL:  r_cfg.ddr_refill  <= i_cfg_data[CREDIT_W-1:0];
                CFG_L2_ACC_MAX:  r_cfg.l2_acc_max  <= i_cfg_data[CREDIT_W-1:0];
                CFG_L2_RD_MAX:   r_cfg.l2_rd_max   <= i_cfg_data[CREDIT_W-1:0];
                CFG_L2_WR_MAX:   r_cfg.l2_wr_max   <= i_cfg_data[CREDIT_W-1:0];
                CFG_QUEUE_LIMIT: r_cfg.queue_limit <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify incoming beats
    mca_front u_front (
        .i_req         (i_req),
        .i_l2_base     (r_l2_base),
        .i_l2_win_size (r_l2_win_size),
        .o_cls         (cls_in)
    );

    // Decouple front and back
    mca_fifo #(
        .W     ($bits(t_cls)),
        .DEPTH (CLS_DEPTH)
    ) u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cls_in),
        .o_full  (full),
        .i_pop   (cls_pop),
        .o_data  (cls_out),
        .o_empty (cls_empty)
    );

    // Apply credits and build results
    mca_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cls       (cls_out),
        .i_cls_valid (!cls_empty),
        .o_cls_pop   (cls_pop),
        .o_rsp       (rsp_in),
        .i_rsp_ready (!rsp_full),
        .o_rsp_push  (rsp_push)
    );

    // Hold results until popped
    mca_fifo #(
        .W     ($bits(t_rsp)),
        .DEPTH (RSP_DEPTH)
    ) u_rsp_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rsp_push),
        .i_data  (rsp_in),
        .o_full  (rsp_full),
        .i_pop   (pop),
        .o_data  (o_rsp),
        .o_empty (empty)
    );

endmodule

// ----- verif/tb_memory_credit_admission.sv -----
// Testbench for memory_credit_admission: directed table, then randomized phases, every
// result beat checked against a hand-written verdict or an in-bench credit admission predictor.
// Depends on mca_pkg and the memory_credit_admission RTL.
`timescale 1ns / 1ps

module tb_memory_credit_admission;
    import mca_pkg::*;

    localparam int IDLE_PCT     = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 4;
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        t_cfg_idx                idx;
        logic [CFG_DATA_W-1:0]   data;
        t_req                    req;
        bit                      known;
        t_rsp                    want;
    } t_stim_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  push       = 1'b0;
    t_req                  i_req      = '0;
    logic                  full;
    logic                  pop        = 1'b0;
    t_rsp                  o_rsp;
    logic                  empty;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Predictor copy of the registers
    logic [ADDR_W-1:0]   cfg_l2_base;
    logic [ADDR_W-1:0]   cfg_l2_span;
    logic [CREDIT_W-1:0] cfg_ddr_max;
    logic [CREDIT_W-1:0] cfg_ddr_refill;
    logic [CREDIT_W-1:0] cfg_acc_max;
    logic [CREDIT_W-1:0] cfg_rd_max;
    logic [CREDIT_W-1:0] cfg_wr_max;
    logic [COUNT_W-1:0]  cfg_qlimit;

    // Predictor copy of the credits and the in-flight count
    logic [CREDIT_W-1:0] ddr_cr;
    logic [CREDIT_W-1:0] acc_cr;
    logic [CREDIT_W-1:0] rd_cr;
    logic [CREDIT_W-1:0] wr_cr;
    logic [COUNT_W-1:0]  inflight;

    t_rsp      verdict_q[$];
    t_stim_row plan[$];
    int        fail_count = 0;
    int        hold_asks  = 0;
    bit        steady     = 1'b0;

    memory_credit_admission uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .i_req     (i_req),
        .full      (full),
        .pop       (pop),
        .o_rsp     (o_rsp),
        .empty     (empty),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Add a tick refill to a credit and clamp at its ceiling
    function automatic logic [CREDIT_W-1:0] credit_topup(logic [CREDIT_W-1:0] cr,
                                                         logic [CREDIT_W-1:0] add,
                                                         logic [CREDIT_W-1:0] ceil_val);
        logic [CREDIT_W:0] sum;
        sum = {1'b0, cr} + {1'b0, add};
        return (sum > {1'b0, ceil_val}) ? ceil_val : sum[CREDIT_W-1:0];
    endfunction

    // Classify, admit and charge one request; return the verdict beat it should produce
    function automatic t_rsp predict_admission(t_req r);
        logic [ADDR_W:0]     win_end;
        logic                hit;
        logic                is_wr;
        logic [CREDIT_W-1:0] acc;
        logic [CREDIT_W-1:0] rw;
        logic [SIZE_W:0]     rounded;
        logic [RSPN_W-1:0]   nrsp;
        logic [COUNT_W:0]    total;
        t_rsp                o;
        o       = '0;
        nrsp    = '0;
        win_end = {1'b0, cfg_l2_base} + {1'b0, cfg_l2_span};
        hit     = (r.address >= cfg_l2_base) && ({1'b0, r.address} < win_end);
        case (r.func)
            FUNC_TICK: begin
                ddr_cr = credit_topup(ddr_cr, cfg_ddr_refill, cfg_ddr_max);
                acc_cr = credit_topup(acc_cr, L2_ACCESS_REFILL, cfg_acc_max);
                rd_cr  = credit_topup(rd_cr, L2_READ_REFILL, cfg_rd_max);
                wr_cr  = credit_topup(wr_cr, L2_WRITE_REFILL, cfg_wr_max);
            end
            FUNC_CMPL: begin
                if (inflight != '0) inflight = inflight - 1'b1;
            end
            default: begin
                is_wr = (r.func == FUNC_WRITE);
                acc   = hit ? acc_cr : ddr_cr;
                rw    = hit ? (is_wr ? wr_cr : rd_cr) : ddr_cr;
                if (inflight < cfg_qlimit && r.byte_count < acc && r.byte_count < rw) begin
                    o.accepted = 1'b1;
                    // Split reads return one beat per started 128-byte block
                    if (!is_wr && r.channel == SPLIT_CHANNEL) begin
                        rounded = {1'b0, r.byte_count}
                                  + (SIZE_W + 1)'((1 << SPLIT_SHIFT) - 1);
                        nrsp    = RSPN_W'(rounded >> SPLIT_SHIFT);
                    end else begin
                        nrsp = RSPN_W'(1);
                    end
                    total    = {1'b0, inflight} + (COUNT_W + 1)'(nrsp);
                    inflight = total[COUNT_W] ? '1 : total[COUNT_W-1:0];
                    if (hit) begin
                        acc_cr = acc_cr - r.byte_count;
                        if (is_wr) wr_cr = wr_cr - r.byte_count;
                        else rd_cr = rd_cr - r.byte_count;
                    end else begin
                        // DDR pays twice: once plain, once floored at zero
                        ddr_cr = ddr_cr - r.byte_count;
                        ddr_cr = (ddr_cr > r.byte_count) ? ddr_cr - r.byte_count : '0;
                    end
                end
            end
        endcase
        o.in_l2          = hit;
        o.response_count = nrsp;
        o.outstanding    = inflight;
        o.ddr_credit_now = ddr_cr;
        return o;
    endfunction

    function automatic logic [ADDR_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_W-1:0];
    endfunction

    // Draw one request; aim addresses at the window and its edges part of the time
    function automatic t_req random_request(int p_tick, int p_read, int p_write, int p_split,
                                            bit relief);
        t_req r;
        int   roll;
        r.address = rand48();
        roll = $urandom_range(99);
        // Bias toward completions while the queue limit blocks everything
        if (relief && inflight >= cfg_qlimit && $urandom_range(1) == 1) roll = 99;
        if (roll < p_tick) r.func = FUNC_TICK;
        else if (roll < p_tick + p_read) r.func = FUNC_READ;
        else if (roll < p_tick + p_read + p_write) r.func = FUNC_WRITE;
        else r.func = FUNC_CMPL;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                if (cfg_l2_span != '0) r.address = cfg_l2_base + rand48() % cfg_l2_span;
            end
            4: begin
                case ($urandom_range(3))
                    0: r.address = cfg_l2_base - 1'b1;
                    1: r.address = cfg_l2_base;
                    2: r.address = cfg_l2_base + cfg_l2_span - 1'b1;
                    default: r.address = cfg_l2_base + cfg_l2_span;
                endcase
            end
            default: ;
        endcase
        case ($urandom_range(9))
            0: r.byte_count = '0;
            1: r.byte_count = '1;
            2, 3, 4, 5: r.byte_count = SIZE_W'($urandom_range(255));
            6, 7: r.byte_count = SIZE_W'($urandom_range(4095));
            default: r.byte_count = SIZE_W'($urandom_range(65535));
        endcase
        r.channel = ($urandom_range(99) < p_split) ? SPLIT_CHANNEL : CHAN_W'($urandom_range(15));
        return r;
    endfunction

    function automatic void add_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row      = '{kind: ROW_CFG, idx: idx, data: data, req: '0, known: 1'b0, want: '0};
        plan.insert(plan.size(), row);
    endfunction

    function automatic void add_item(t_func f, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] n,
                                     logic [CHAN_W-1:0] ch);
        t_stim_row row;
        row = '{kind: ROW_ITEM, idx: CFG_L2_BASE, data: '0, req: '0, known: 1'b0, want: '0};
        row.req.func       = f;
        row.req.address    = a;
        row.req.byte_count = n;
        row.req.channel    = ch;
        plan.insert(plan.size(), row);
    endfunction

    // Item whose verdict is written out by hand
    function automatic void add_known(t_func f, logic [ADDR_W-1:0] a, logic [SIZE_W-1:0] n,
                                      logic [CHAN_W-1:0] ch, logic acc, logic l2,
                                      logic [RSPN_W-1:0] nrsp, logic [COUNT_W-1:0] outs,
                                      logic [CREDIT_W-1:0] ddr);
        add_item(f, a, n, ch);
        plan[$].known                = 1'b1;
        plan[$].want.accepted        = acc;
        plan[$].want.in_l2           = l2;
        plan[$].want.response_count  = nrsp;
        plan[$].want.outstanding     = outs;
        plan[$].want.ddr_credit_now  = ddr;
    endfunction

    task automatic check_beat(t_rsp got, t_rsp want);
        if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            fail_count++;
        end
        if (got.in_l2 !== want.in_l2) begin
            $error("in_l2: expected %0d, got %0d", want.in_l2, got.in_l2);
            fail_count++;
        end
        if (got.response_count !== want.response_count) begin
            $error("response_count: expected %0d, got %0d",
                   want.response_count, got.response_count);
            fail_count++;
        end
        if (got.outstanding !== want.outstanding) begin
            $error("outstanding: expected %0d, got %0d", want.outstanding, got.outstanding);
            fail_count++;
        end
        if (got.ddr_credit_now !== want.ddr_credit_now) begin
            $error("ddr_credit_now: expected 0x%0h, got 0x%0h",
                   want.ddr_credit_now, got.ddr_credit_now);
            fail_count++;
        end
    endtask

    // Offer one beat, hold it until taken, then record its verdict
    task automatic send_item(t_req r, bit known, t_rsp want);
        t_rsp guess;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        guess = predict_admission(r);
        verdict_q.insert(verdict_q.size(), known ? want : guess);
    endtask

    // Stop offering and wait until every verdict has come back
    task automatic settle_out();
        int waited;
        waited = 0;
        push <= 1'b0;
        while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (verdict_q.size() != 0) begin
            $error("%0d expected result beats never arrived", verdict_q.size());
            fail_count++;
            verdict_q.delete();
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write one register and mirror it; the caller drops the write enable
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            CFG_L2_BASE:     cfg_l2_base    = v[ADDR_W-1:0];
            CFG_L2_WIN_SIZE: cfg_l2_span    = v[ADDR_W-1:0];
            CFG_DDR_MAX:     cfg_ddr_max    = v[CREDIT_W-1:0];
            CFG_DDR_REFILL:  cfg_ddr_refill = v[CREDIT_W-1:0];
            CFG_L2_ACC_MAX:  cfg_acc_max    = v[CREDIT_W-1:0];
            CFG_L2_RD_MAX:   cfg_rd_max     = v[CREDIT_W-1:0];
            CFG_L2_WR_MAX:   cfg_wr_max     = v[CREDIT_W-1:0];
            default:         cfg_qlimit     = v[COUNT_W-1:0];
        endcase
    endtask

    task automatic load_settings(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] span,
                                 logic [CREDIT_W-1:0] dmax, logic [CREDIT_W-1:0] drefill,
                                 logic [CREDIT_W-1:0] amax, logic [CREDIT_W-1:0] rmax,
                                 logic [CREDIT_W-1:0] wmax, logic [COUNT_W-1:0] qlim);
        settle_out();
        write_reg(CFG_L2_BASE, base);
        write_reg(CFG_L2_WIN_SIZE, span);
        write_reg(CFG_DDR_MAX, dmax);
        write_reg(CFG_DDR_REFILL, drefill);
        write_reg(CFG_L2_ACC_MAX, amax);
        write_reg(CFG_L2_RD_MAX, rmax);
        write_reg(CFG_L2_WR_MAX, wmax);
        write_reg(CFG_QUEUE_LIMIT, qlim);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int items, int p_tick, int p_read, int p_write, int p_split,
                             bit relief, int hold_at);
        for (int n = 0; n < items; n++) begin
            if (n == hold_at) hold_asks++;
            send_item(random_request(p_tick, p_read, p_write, p_split, relief), 1'b0, '0);
        end
    endtask

    // Result side: check each popped beat, randomize pop, honor hold-off requests
    initial begin : result_side
        t_rsp want;
        int   hold_left;
        int   hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with nothing expected: %p", o_rsp);
                    fail_count++;
                end else begin
                    want = verdict_q[0];
                    verdict_q.delete(0);
                    check_beat(o_rsp, want);
                end
            end
            if (hold_asks != hold_seen) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Request side: reset, directed table, then randomized phases
    initial begin : request_side
        cfg_l2_base    = '0;
        cfg_l2_span    = '0;
        cfg_ddr_max    = '0;
        cfg_ddr_refill = '0;
        cfg_acc_max    = '0;
        cfg_rd_max     = '0;
        cfg_wr_max     = '0;
        cfg_qlimit     = QUEUE_LIMIT_RST;
        ddr_cr         = '0;
        acc_cr         = '0;
        rd_cr          = '0;
        wr_cr          = '0;
        inflight       = '0;

        // Out of reset every credit is zero, so nothing is admitted
        add_known(FUNC_READ, 48'h0, 16'h0, 4'd0, 1'b0, 1'b0, 10'd0, 11'd0, 20'h0);
        add_known(FUNC_CMPL, 48'h0, 16'h0, 4'd0, 1'b0, 1'b0, 10'd0, 11'd0, 20'h0);
        add_known(FUNC_TICK, 48'h0, 16'h0, 4'd0, 1'b0, 1'b0, 10'd0, 11'd0, 20'h0);
        add_cfg(CFG_DDR_MAX, 48'hF_FFFF);
        add_cfg(CFG_DDR_REFILL, 48'hF_FFFF);
        add_cfg(CFG_L2_BASE, 48'h1000);
        add_cfg(CFG_L2_WIN_SIZE, 48'h1000);
        add_cfg(CFG_L2_ACC_MAX, 48'hF_FFFF);
        add_cfg(CFG_L2_RD_MAX, 48'hF_FFFF);
        add_cfg(CFG_L2_WR_MAX, 48'hF_FFFF);
        // DDR fills in one tick, L2 credits reach 64
        add_known(FUNC_TICK, 48'h0, 16'h0, 4'd0, 1'b0, 1'b0, 10'd0, 11'd0, 20'hF_FFFF);
        // Largest DDR write pays its size twice
        add_known(FUNC_WRITE, 48'h0, 16'hFFFF, 4'd0, 1'b1, 1'b0, 10'd1, 11'd1, 20'hE_0001);
        // Zero-byte split read is admitted but adds nothing
        add_known(FUNC_READ, 48'h1000, 16'h0, 4'd10, 1'b1, 1'b1, 10'd0, 11'd1, 20'hE_0001);
        add_item(FUNC_READ, 48'h1FFF, 16'd63, 4'd10);
        add_item(FUNC_READ, 48'h2000, 16'd129, 4'd10);
        add_item(FUNC_READ, 48'h0FFF, 16'd128, 4'd10);
        add_item(FUNC_WRITE, 48'h1800, 16'd64, 4'd3);
        add_item(FUNC_WRITE, 48'h1800, 16'd63, 4'd10);
        add_item(FUNC_CMPL, 48'h0, 16'h0, 4'd0);
        add_item(FUNC_CMPL, 48'h0, 16'h0, 4'd0);
        add_item(FUNC_READ, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 4'd15);
        // Window running off the top of the address space
        add_cfg(CFG_L2_BASE, 48'hFFFF_FFFF_F000);
        add_cfg(CFG_L2_WIN_SIZE, 48'hFFFF_FFFF_FFFF);
        add_item(FUNC_TICK, 48'hFFFF_FFFF_FFFF, 16'h0, 4'd0);
        add_item(FUNC_READ, 48'hFFFF_FFFF_FFFF, 16'h0, 4'd10);
        add_item(FUNC_WRITE, 48'h0, 16'd1, 4'd0);
        add_cfg(CFG_QUEUE_LIMIT, 48'd0);
        add_item(FUNC_READ, 48'h0, 16'h0, 4'd0);
        // Lowered ceiling only bites at the next tick
        add_cfg(CFG_QUEUE_LIMIT, 48'd2047);
        add_cfg(CFG_DDR_MAX, 48'd5);
        add_item(FUNC_WRITE, 48'h0, 16'd100, 4'd0);
        add_item(FUNC_TICK, 48'h0, 16'h0, 4'd0);
        add_item(FUNC_READ, 48'h0, 16'd4, 4'd0);
        add_item(FUNC_CMPL, 48'h0, 16'h0, 4'd0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int k = 0; k < plan.size(); k++) begin
            if (plan[k].kind == ROW_CFG) begin
                settle_out();
                write_reg(plan[k].idx, plan[k].data);
                i_cfg_we <= 1'b0;
            end else begin
                send_item(plan[k].req, plan[k].known, plan[k].want);
            end
        end

        // Tight credits and a tiny queue limit
        load_settings(rand48(), 48'h400, 20'd300, 20'd40, 20'd200, 20'd150, 20'd150, 11'd3);
        run_phase(300, 25, 30, 25, 30, 1'b1, -1);

        // Moderate credits, back to back on both sides
        load_settings(rand48(), 48'h10_0000, 20'd4000, 20'd500, 20'd3000, 20'd2000, 20'd2000,
                      11'd16);
        steady = 1'b1;
        run_phase(300, 20, 35, 25, 30, 1'b1, -1);
        steady = 1'b0;

        // Every register at zero
        load_settings('0, '0, '0, '0, '0, '0, '0, '0);
        run_phase(150, 25, 30, 25, 30, 1'b1, -1);

        // Fully random settings
        repeat (2) begin
            load_settings(rand48(), rand48() >> $urandom_range(47),
                          CREDIT_W'($urandom_range(20'hF_FFFF)),
                          CREDIT_W'($urandom_range(20'hF_FFFF)),
                          CREDIT_W'($urandom_range(20'hF_FFFF)),
                          CREDIT_W'($urandom_range(20'hF_FFFF)),
                          CREDIT_W'($urandom_range(20'hF_FFFF)),
                          COUNT_W'($urandom_range(1024, 256)));
            run_phase(300, 20, 35, 25, 30, 1'b1, -1);
        end

        // All credit maxima, every address but the highest as L2; stall the result side to back up the input
        load_settings('0, '1, '1, '1, '1, '1, '1, 11'd1024);
        run_phase(300, 20, 35, 25, 20, 1'b1, 40);

        // Pile up split reads until the outstanding count pins at its ceiling
        load_settings(48'hFFFF_FFFF_0000, 48'h1_0000, '1, '1, '1, '1, '1, 11'd2047);
        run_phase(220, 30, 65, 5, 90, 1'b0, -1);

        settle_out();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/mca_pkg.sv
rtl/core/mca_fifo.sv
rtl/core/mca_front.sv
rtl/core/mca_back.sv
rtl/core/memory_credit_admission.sv
verif/tb_memory_credit_admission.sv
